FILE: design/rvse_pkg.sv
`default_nettype none

package rvse_pkg;

    localparam int XLEN          = 32;
    localparam int REG_COUNT     = 32;
    localparam int REG_AW        = $clog2(REG_COUNT);
    localparam int LANES         = 4;
    localparam int MEM_BYTES_DEF = 4096;

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [REG_AW-1:0] t_reg_idx;

    // register file write port
    typedef struct packed {
        logic     en;
        t_reg_idx idx;
        t_word    data;
    } t_rf_wr;

endpackage

`default_nettype wire

FILE: design/rvse_ram.sv
`default_nettype none

module rvse_ram #(
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

FILE: design/rvse_regfile.sv
`default_nettype none

module rvse_regfile import rvse_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_rd_en,
    input  wire t_reg_idx i_ra1,
    input  wire t_reg_idx i_ra2,
    output t_word         o_rd1,
    output t_word         o_rd2,
    input  wire t_rf_wr   i_wr
);

    t_word                r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    t_word                r_q1;
    t_word                r_q2;
    logic                 r_v1;
    logic                 r_v2;

    // an entry never written reads as zero; x0 is never written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            if (i_wr.en && (i_wr.idx != '0)) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_v1 <= r_valid[i_ra1];
                r_v2 <= r_valid[i_ra2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx != '0)) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q1 <= r_mem[i_ra1];
            r_q2 <= r_mem[i_ra2];
        end
    end

    assign o_rd1 = r_v1 ? r_q1 : '0;
    assign o_rd2 = r_v2 ? r_q2 : '0;

endmodule

`default_nettype wire

FILE: design/rv32_subset_instruction_execute.sv
`default_nettype none

// Executes one RV32I-subset instruction word per cycle while the master side takes
// results. A word accepted on the slave side passes the operand stage, the memory
// stage and the output register, each registered in turn, before its result word is
// valid on the master side. Back-to-back dependent words run at full rate because
// results are forwarded from the memory stage and from the last register write-back,
// so only back-pressure on the master side slows the flow. Data memory is four
// byte-lane banks read and written in the operand-to-memory stage step, which lets
// unaligned words be loaded or stored in one pass. After reset the data memory is
// cleared one row a cycle, and no word is taken until that is done. MEM_BYTES must
// be a power of two, at least 16. Once ebreak or an invalid encoding halts the core,
// every later word is answered with status 3.
module rv32_subset_instruction_execute import rvse_pkg::*; #(
    parameter int MEM_BYTES = MEM_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [31:0]  i_s_axis_tdata,   // instruction
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic      [103:0] o_m_axis_tdata,   // next_pc, dest_reg, dest_value,
                                                // dest_write, exit_code, zero pad
    output logic      [1:0]   o_m_axis_tuser    // status
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int RW   = AW - 2;
    localparam int ROWS = MEM_BYTES / LANES;

    localparam logic [6:0]  OPC_AUIPC  = 7'h17;
    localparam logic [6:0]  OPC_JAL    = 7'h6F;
    localparam logic [6:0]  OPC_JALR   = 7'h67;
    localparam logic [6:0]  OPC_LOAD   = 7'h03;
    localparam logic [6:0]  OPC_STORE  = 7'h23;
    localparam logic [6:0]  OPC_OPIMM  = 7'h13;
    localparam logic [6:0]  OPC_OP     = 7'h33;
    localparam logic [2:0]  F3_ZERO    = 3'd0;
    localparam logic [2:0]  F3_HALF    = 3'd1;
    localparam logic [2:0]  F3_WORD    = 3'd2;
    localparam logic [2:0]  F3_SLTIU   = 3'd3;
    localparam logic [2:0]  F3_LBU     = 3'd4;
    localparam logic [6:0]  F7_ZERO    = 7'h00;
    localparam logic [6:0]  F7_SUB     = 7'h20;
    localparam logic [31:0] EBREAK_INS = 32'h0010_0073;
    localparam t_reg_idx    EXIT_REG   = t_reg_idx'(10);
    localparam t_word       RESET_PC   = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_EXEC    = 2'd0,
        ST_EBREAK  = 2'd1,
        ST_INVALID = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_AUIPC, OP_JAL, OP_JALR, OP_LW, OP_LBU, OP_SB, OP_SH, OP_SW,
        OP_ADDI, OP_SLTIU, OP_ADD, OP_SUB, OP_EBREAK, OP_INVALID
    } t_op;

    // handshake
    logic adv_b, adv_c, adv_o, accept, b_move, c_move;

    // operand stage
    logic     r_b_valid;
    t_word    r_b_ins;
    t_word    rf_rd1, rf_rd2;
    t_op      b_op;
    t_word    imm_i, imm_s, imm_j, imm_u;
    t_word    s1, s2, x10_val, ea;
    t_word    b_npc, b_val;
    t_reg_idx b_rd;
    t_status  b_status;
    t_word    b_exit;
    logic     b_ld_word, b_ld_byte, b_store;
    logic [1:0] b_st_last;

    // memory banks
    logic [1:0]    lane_j   [LANES];
    logic          bank_we  [LANES];
    logic [RW-1:0] bank_wa  [LANES];
    logic [7:0]    bank_wd  [LANES];
    logic [RW-1:0] bank_ra  [LANES];
    logic [7:0]    bank_q   [LANES];
    logic          r_clearing;
    logic [RW-1:0] r_clr_row;

    // memory stage
    logic     r_c_valid;
    t_word    r_c_npc, r_c_val, r_c_exit;
    t_reg_idx r_c_rd;
    t_status  r_c_status;
    logic     r_c_ld_word, r_c_ld_byte;
    logic [1:0] r_c_off;
    logic [7:0] ld_byte [LANES];
    t_word    c_res;
    logic     c_wen;

    // output and architectural state
    logic     r_o_valid;
    t_word    r_o_npc, r_o_val, r_o_exit;
    t_reg_idx r_o_rd;
    logic     r_o_wen;
    t_status  r_o_status;
    t_word    r_pc;
    logic     r_halted;
    t_word    r_x10;
    logic     r_wb_en;
    t_reg_idx r_wb_rd;
    t_word    r_wb_val;
    t_rf_wr   rf_wr;

    assign adv_o  = !r_o_valid || i_m_axis_tready;
    assign adv_c  = !r_c_valid || adv_o;
    assign adv_b  = !r_b_valid || adv_c;
    assign o_s_axis_tready = adv_b && !r_clearing;
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign b_move = r_b_valid && adv_c;
    assign c_move = r_c_valid && adv_o;

    rvse_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_ra1   (i_s_axis_tdata[19:15]),
        .i_ra2   (i_s_axis_tdata[24:20]),
        .o_rd1   (rf_rd1),
        .o_rd2   (rf_rd2),
        .i_wr    (rf_wr)
    );

    // ---------------- operand stage ----------------

    always_comb begin
        priority if (r_b_ins == EBREAK_INS)                     b_op = OP_EBREAK;
        else if (r_b_ins[6:0] == OPC_AUIPC)                     b_op = OP_AUIPC;
        else if (r_b_ins[6:0] == OPC_JAL)                       b_op = OP_JAL;
        else if (r_b_ins[6:0] == OPC_JALR && r_b_ins[14:12] == F3_ZERO)
                                                                b_op = OP_JALR;
        else if (r_b_ins[6:0] == OPC_LOAD && r_b_ins[14:12] == F3_WORD)
                                                                b_op = OP_LW;
        else if (r_b_ins[6:0] == OPC_LOAD && r_b_ins[14:12] == F3_LBU)
                                                                b_op = OP_LBU;
        else if (r_b_ins[6:0] == OPC_STORE && r_b_ins[14:12] == F3_ZERO)
                                                                b_op = OP_SB;
        else if (r_b_ins[6:0] == OPC_STORE && r_b_ins[14:12] == F3_HALF)
                                                                b_op = OP_SH;
        else if (r_b_ins[6:0] == OPC_STORE && r_b_ins[14:12] == F3_WORD)
                                                                b_op = OP_SW;
        else if (r_b_ins[6:0] == OPC_OPIMM && r_b_ins[14:12] == F3_ZERO)
                                                                b_op = OP_ADDI;
        else if (r_b_ins[6:0] == OPC_OPIMM && r_b_ins[14:12] == F3_SLTIU)
                                                                b_op = OP_SLTIU;
        else if (r_b_ins[6:0] == OPC_OP && r_b_ins[14:12] == F3_ZERO
                 && r_b_ins[31:25] == F7_ZERO)                  b_op = OP_ADD;
        else if (r_b_ins[6:0] == OPC_OP && r_b_ins[14:12] == F3_ZERO
                 && r_b_ins[31:25] == F7_SUB)                   b_op = OP_SUB;
        else                                                    b_op = OP_INVALID;
    end

    assign imm_i = {{20{r_b_ins[31]}}, r_b_ins[31:20]};
    assign imm_s = {{20{r_b_ins[31]}}, r_b_ins[31:25], r_b_ins[11:7]};
    assign imm_j = {{11{r_b_ins[31]}}, r_b_ins[31], r_b_ins[19:12], r_b_ins[20],
                    r_b_ins[30:21], 1'b0};
    assign imm_u = {r_b_ins[31:12], 12'h000};

    // forwarding: memory stage is youngest, then the last write-back
    always_comb begin
        s1 = rf_rd1;
        s2 = rf_rd2;
        x10_val = r_x10;
        if (r_wb_en && r_wb_rd == r_b_ins[19:15]) begin
            s1 = r_wb_val;
        end
        if (r_wb_en && r_wb_rd == r_b_ins[24:20]) begin
            s2 = r_wb_val;
        end
        if (c_wen && r_c_rd == r_b_ins[19:15]) begin
            s1 = c_res;
        end
        if (c_wen && r_c_rd == r_b_ins[24:20]) begin
            s2 = c_res;
        end
        if (c_wen && r_c_rd == EXIT_REG) begin
            x10_val = c_res;
        end
    end

    assign ea = s1 + ((b_op == OP_SB || b_op == OP_SH || b_op == OP_SW) ? imm_s : imm_i);

    always_comb begin
        b_npc     = r_pc + 32'd4;
        b_val     = '0;
        b_rd      = '0;
        b_status  = ST_EXEC;
        b_exit    = '0;
        b_ld_word = 1'b0;
        b_ld_byte = 1'b0;
        b_store   = 1'b0;
        b_st_last = 2'd0;
        if (r_halted) begin
            b_npc    = r_pc;
            b_status = ST_IGNORED;
        end else begin
            unique case (b_op)
                OP_EBREAK: begin
                    b_npc    = r_pc;
                    b_status = ST_EBREAK;
                    b_exit   = x10_val;
                end
                OP_AUIPC: begin
                    b_val = r_pc + imm_u;
                    b_rd  = r_b_ins[11:7];
                end
                OP_JAL: begin
                    b_npc = r_pc + imm_j;
                    b_val = r_pc + 32'd4;
                    b_rd  = r_b_ins[11:7];
                end
                OP_JALR: begin
                    b_npc = (s1 + imm_i) & ~32'd1;
                    b_val = r_pc + 32'd4;
                    b_rd  = r_b_ins[11:7];
                end
                OP_LW: begin
                    b_ld_word = 1'b1;
                    b_rd      = r_b_ins[11:7];
                end
                OP_LBU: begin
                    b_ld_byte = 1'b1;
                    b_rd      = r_b_ins[11:7];
                end
                OP_SB: begin
                    b_store   = 1'b1;
                    b_st_last = 2'd0;
                end
                OP_SH: begin
                    b_store   = 1'b1;
                    b_st_last = 2'd1;
                end
                OP_SW: begin
                    b_store   = 1'b1;
                    b_st_last = 2'd3;
                end
                OP_ADDI: begin
                    b_val = s1 + imm_i;
                    b_rd  = r_b_ins[11:7];
                end
                OP_SLTIU: begin
                    b_val = {31'd0, (s1 < imm_i)};
                    b_rd  = r_b_ins[11:7];
                end
                OP_ADD: begin
                    b_val = s1 + s2;
                    b_rd  = r_b_ins[11:7];
                end
                OP_SUB: begin
                    b_val = s1 - s2;
                    b_rd  = r_b_ins[11:7];
                end
                OP_INVALID: begin
                    b_npc    = r_pc;
                    b_status = ST_INVALID;
                end
                default: begin
                    b_npc    = r_pc;
                    b_status = ST_INVALID;
                end
            endcase
        end
    end

    // lane b holds byte j = b - offset of the access; it sits one row on if b < offset
    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            lane_j[b]  = 2'(b) - ea[1:0];
            bank_ra[b] = ea[AW-1:2] + {{(RW-1){1'b0}}, (2'(b) < ea[1:0])};
            if (r_clearing) begin
                bank_we[b] = 1'b1;
                bank_wa[b] = r_clr_row;
                bank_wd[b] = 8'h00;
            end else begin
                bank_we[b] = b_move && b_store && (lane_j[b] <= b_st_last);
                bank_wa[b] = bank_ra[b];
                bank_wd[b] = 8'(s2 >> {lane_j[b], 3'b000});
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_bank
        rvse_ram #(
            .ADDR_W (RW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (bank_wa[g]),
            .i_wdata (bank_wd[g]),
            .i_re    (b_move),
            .i_raddr (bank_ra[g]),
            .o_rdata (bank_q[g])
        );
    end

    // ---------------- memory stage ----------------

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            ld_byte[j] = bank_q[2'(j) + r_c_off];
        end
        if (r_c_ld_word) begin
            c_res = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
        end else if (r_c_ld_byte) begin
            c_res = {24'd0, ld_byte[0]};
        end else begin
            c_res = r_c_val;
        end
    end

    // dest index is zeroed for words that write nothing
    assign c_wen = r_c_valid && (r_c_rd != '0);

    assign rf_wr.en   = c_move && c_wen;
    assign rf_wr.idx  = r_c_rd;
    assign rf_wr.data = c_res;

    // ---------------- registers ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pc       <= RESET_PC;
            r_halted   <= 1'b0;
            r_x10      <= '0;
            r_wb_en    <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            if (adv_b) begin
                r_b_valid <= accept;
            end
            if (adv_c) begin
                r_c_valid <= r_b_valid;
            end
            if (adv_o) begin
                r_o_valid <= r_c_valid;
            end
            if (b_move) begin
                r_pc <= b_npc;
                if (b_status == ST_EBREAK || b_status == ST_INVALID) begin
                    r_halted <= 1'b1;
                end
            end
            if (c_move && c_wen) begin
                r_wb_en <= 1'b1;
                if (r_c_rd == EXIT_REG) begin
                    r_x10 <= c_res;
                end
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == RW'(ROWS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_ins <= i_s_axis_tdata;
        end
        if (b_move) begin
            r_c_npc     <= b_npc;
            r_c_val     <= b_val;
            r_c_rd      <= b_rd;
            r_c_status  <= b_status;
            r_c_exit    <= b_exit;
            r_c_ld_word <= b_ld_word;
            r_c_ld_byte <= b_ld_byte;
            r_c_off     <= ea[1:0];
        end
        if (c_move) begin
            r_o_npc    <= r_c_npc;
            r_o_rd     <= r_c_rd;
            r_o_val    <= c_res;
            r_o_wen    <= c_wen;
            r_o_status <= r_c_status;
            r_o_exit   <= r_c_exit;
        end
        if (c_move && c_wen) begin
            r_wb_rd  <= r_c_rd;
            r_wb_val <= c_res;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_exit, r_o_wen, r_o_val, r_o_rd, r_o_npc};
    assign o_m_axis_tuser  = r_o_status;

    // ---------------- assertions ----------------

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_s_axis_tready)
        else $error("word accepted during memory clear");

    a_ignored_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == ST_IGNORED) |-> r_halted)
        else $error("ignored status while not halted");

    a_halted_pc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_move && r_halted) |=> (r_pc == $past(r_pc)))
        else $error("program counter moved while halted");

    a_dest_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[69])
            |-> (o_m_axis_tdata[36:32] != 5'd0 && o_m_axis_tuser == ST_EXEC))
        else $error("register write reported on x0 or on a halt");

endmodule

`default_nettype wire

FILE: sim/rv32_subset_instruction_execute_tb.sv
module rv32_subset_instruction_execute_tb;
    import rvse_pkg::*;

    localparam int MEM_BYTES    = MEM_BYTES_DEF;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 400;

    // opcodes and function fields
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6F;

    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SLTIU = 3'd3;
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [2:0] F3_LH    = 3'd1;
    localparam logic [2:0] F3_LW    = 3'd2;
    localparam logic [2:0] F3_LBU   = 3'd4;
    localparam logic [2:0] F3_SB    = 3'd0;
    localparam logic [2:0] F3_SH    = 3'd1;
    localparam logic [2:0] F3_SW    = 3'd2;
    localparam logic [2:0] F3_SBAD  = 3'd3;

    localparam logic [6:0] F7_ADD = 7'h00;
    localparam logic [6:0] F7_MUL = 7'h01;
    localparam logic [6:0] F7_SUB = 7'h20;

    localparam t_word EBREAK_WORD = 32'h0010_0073;
    localparam t_word ECALL_WORD  = 32'h0000_0073;
    localparam t_word RESET_PC    = 32'h8000_0000;

    localparam t_reg_idx ZERO_REG = 5'd0;
    localparam t_reg_idx EXIT_REG = 5'd10;

    typedef enum logic [1:0] {
        ST_EXECUTED = 2'd0,
        ST_EBREAK   = 2'd1,
        ST_INVALID  = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum int {
        K_AUIPC, K_JAL, K_JALR, K_LW, K_LBU, K_SB, K_SH, K_SW,
        K_ADDI, K_SLTIU, K_ADD, K_SUB
    } t_op_kind;

    typedef struct packed {
        t_word    next_pc;
        t_reg_idx dest_reg;
        t_word    dest_value;
        logic     dest_write;
        t_status  status;
        t_word    exit_code;
    } t_exec_result;

    logic         clk;
    logic         rst_n   = 1'b0;
    logic         s_valid = 1'b0;
    t_word        s_data  = '0;
    logic         m_ready = 1'b0;
    logic         s_ready;
    logic         m_valid;
    logic [103:0] m_data;
    logic [1:0]   m_user;

    // architectural state as the core should hold it
    t_word arch_pc;
    t_word arch_regs [REG_COUNT];
    logic [7:0] arch_mem [MEM_BYTES];
    logic  arch_halted;

    t_exec_result pending_results[$];
    int fail_count = 0;
    bit gaps_on    = 1'b1;
    bit hold_req   = 1'b0;

    rv32_subset_instruction_execute #(
        .MEM_BYTES(MEM_BYTES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("rv32_subset_instruction_execute_tb failed");
        $finish;
    end

    // ---------------- encoders ----------------
    function automatic t_word enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                    input t_reg_idx rd, input t_reg_idx rs1,
                                    input logic [11:0] imm);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic t_word enc_s(input logic [2:0] f3, input t_reg_idx rs1,
                                    input t_reg_idx rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic t_word enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                    input t_reg_idx rd, input t_reg_idx rs1,
                                    input t_reg_idx rs2);
        return {f7, rs2, rs1, f3, rd, OP_REG};
    endfunction

    function automatic t_word enc_u(input logic [6:0] opc, input t_reg_idx rd,
                                    input logic [19:0] imm);
        return {imm, rd, opc};
    endfunction

    function automatic t_word enc_j(input t_reg_idx rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // ---------------- expected behaviour ----------------
    function automatic t_word load_bytes(input t_word addr, input int n);
        t_word v;
        v = '0;
        for (int k = 0; k < n; k++)
            v[8*k +: 8] = arch_mem[(addr + k) % MEM_BYTES];
        return v;
    endfunction

    function automatic t_exec_result execute_word(input t_word w);
        t_exec_result r;
        logic [6:0]   opc;
        logic [6:0]   f7;
        logic [2:0]   f3;
        t_reg_idx     rd;
        t_word        s1, s2, imm_i, imm_s, imm_j, val, npc, addr;
        logic         writes, known;
        opc    = w[6:0];
        f3     = w[14:12];
        f7     = w[31:25];
        rd     = w[11:7];
        s1     = arch_regs[w[19:15]];
        s2     = arch_regs[w[24:20]];
        imm_i  = {{20{w[31]}}, w[31:20]};
        imm_s  = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_j  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        r      = '0;
        r.next_pc = arch_pc;
        if (arch_halted) begin
            r.status = ST_IGNORED;
            return r;
        end
        if (w == EBREAK_WORD) begin
            r.status    = ST_EBREAK;
            r.exit_code = arch_regs[EXIT_REG];
            arch_halted = 1'b1;
            return r;
        end
        npc    = arch_pc + 32'd4;
        val    = '0;
        writes = 1'b0;
        known  = 1'b1;
        case (opc)
            OP_AUIPC: begin
                val    = arch_pc + {w[31:12], 12'b0};
                writes = 1'b1;
            end
            OP_JAL: begin
                npc    = arch_pc + imm_j;
                val    = arch_pc + 32'd4;
                writes = 1'b1;
            end
            OP_JALR: begin
                if (f3 == F3_JALR) begin
                    npc    = (s1 + imm_i) & ~32'd1;
                    val    = arch_pc + 32'd4;
                    writes = 1'b1;
                end else begin
                    known = 1'b0;
                end
            end
            OP_LOAD: begin
                if (f3 == F3_LW) begin
                    val    = load_bytes(s1 + imm_i, 4);
                    writes = 1'b1;
                end else if (f3 == F3_LBU) begin
                    val    = load_bytes(s1 + imm_i, 1);
                    writes = 1'b1;
                end else begin
                    known = 1'b0;
                end
            end
            OP_STORE: begin
                if (f3 <= F3_SW) begin
                    addr = s1 + imm_s;
                    for (int k = 0; k < (1 << f3); k++)
                        arch_mem[(addr + k) % MEM_BYTES] = s2[8*k +: 8];
                end else begin
                    known = 1'b0;
                end
            end
            OP_IMM: begin
                if (f3 == F3_ADD) begin
                    val    = s1 + imm_i;
                    writes = 1'b1;
                end else if (f3 == F3_SLTIU) begin
                    val    = (s1 < imm_i) ? 32'd1 : 32'd0;
                    writes = 1'b1;
                end else begin
                    known = 1'b0;
                end
            end
            OP_REG: begin
                if (f3 == F3_ADD && f7 == F7_ADD) begin
                    val    = s1 + s2;
                    writes = 1'b1;
                end else if (f3 == F3_ADD && f7 == F7_SUB) begin
                    val    = s1 - s2;
                    writes = 1'b1;
                end else begin
                    known = 1'b0;
                end
            end
            default: known = 1'b0;
        endcase
        if (!known) begin
            r.status    = ST_INVALID;
            arch_halted = 1'b1;
            return r;
        end
        if (writes && rd != ZERO_REG)
            arch_regs[rd] = val;
        arch_pc   = npc;
        r.next_pc = npc;
        if (writes) begin
            r.dest_reg   = rd;
            r.dest_value = val;
            r.dest_write = (rd != ZERO_REG);
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // mostly a handful of registers so results feed each other closely
    function automatic t_reg_idx pick_reg();
        if ($urandom_range(0, 3) == 0)
            return t_reg_idx'($urandom_range(0, 31));
        return t_reg_idx'($urandom_range(1, 6));
    endfunction

    function automatic t_word random_program_word();
        t_op_kind    kind;
        t_reg_idx    rd, rs1, rs2;
        logic [11:0] imm;
        kind = t_op_kind'($urandom_range(0, 11));
        rd   = pick_reg();
        rs1  = pick_reg();
        rs2  = pick_reg();
        imm  = 12'($urandom());
        // memory traffic: often x0-based with a small offset so addresses collide
        if (kind inside {K_LW, K_LBU, K_SB, K_SH, K_SW} && $urandom_range(0, 1) == 0) begin
            rs1 = ZERO_REG;
            imm = 12'($urandom_range(0, 79) - 16);
        end
        if (kind == K_JALR && $urandom_range(0, 3) == 0)
            rs1 = rd;
        case (kind)
            K_AUIPC: return enc_u(OP_AUIPC, rd, 20'($urandom()));
            K_JAL:   return enc_j(rd, {21'($urandom()) & ~21'd1});
            K_JALR:  return enc_i(OP_JALR, F3_JALR, rd, rs1, imm);
            K_LW:    return enc_i(OP_LOAD, F3_LW, rd, rs1, imm);
            K_LBU:   return enc_i(OP_LOAD, F3_LBU, rd, rs1, imm);
            K_SB:    return enc_s(F3_SB, rs1, rs2, imm);
            K_SH:    return enc_s(F3_SH, rs1, rs2, imm);
            K_SW:    return enc_s(F3_SW, rs1, rs2, imm);
            K_ADDI:  return enc_i(OP_IMM, F3_ADD, rd, rs1, imm);
            K_SLTIU: return enc_i(OP_IMM, F3_SLTIU, rd, rs1, imm);
            K_ADD:   return enc_r(F7_ADD, F3_ADD, rd, rs1, rs2);
            default: return enc_r(F7_SUB, F3_ADD, rd, rs1, rs2);
        endcase
    endfunction

    task automatic send_word(input t_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        pending_results.push_back(execute_word(w));
    endtask

    // ---------------- result side ----------------
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (gaps_on && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input t_word want, input t_word got);
        if (want !== got) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_exec_result want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: tdata 0x%026h", m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, m_data[31:0]);
                check_field("dest_reg", 32'(want.dest_reg), 32'(m_data[36:32]));
                check_field("dest_value", want.dest_value, m_data[68:37]);
                check_field("dest_write", 32'(want.dest_write), 32'(m_data[69]));
                check_field("exit_code", want.exit_code, m_data[101:70]);
                check_field("status", 32'(want.status), 32'(m_user));
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        gaps_on = 1'b1;
        send_word(enc_i(OP_IMM, F3_ADD, 5'd1, ZERO_REG, 12'h7FF));
        send_word(enc_i(OP_IMM, F3_ADD, 5'd2, ZERO_REG, 12'h800));
        send_word(enc_r(F7_ADD, F3_ADD, 5'd3, 5'd1, 5'd2));
        send_word(enc_r(F7_SUB, F3_ADD, 5'd4, 5'd2, 5'd1));
        send_word(enc_r(F7_ADD, F3_ADD, 5'd31, 5'd1, 5'd1));
        // unsigned compare against a sign-extended immediate
        send_word(enc_i(OP_IMM, F3_SLTIU, 5'd5, 5'd2, 12'hFFF));
        send_word(enc_i(OP_IMM, F3_SLTIU, 5'd6, 5'd1, 12'h001));
        send_word(enc_u(OP_AUIPC, 5'd7, 20'hFFFFF));
        send_word(enc_i(OP_IMM, F3_ADD, ZERO_REG, 5'd1, 12'h005));
        // word straddling the top of memory wraps to address 0
        send_word(enc_s(F3_SW, ZERO_REG, 5'd3, -12'd2));
        send_word(enc_i(OP_LOAD, F3_LW, 5'd8, ZERO_REG, -12'd2));
        send_word(enc_i(OP_LOAD, F3_LBU, 5'd9, ZERO_REG, -12'd1));
        send_word(enc_s(F3_SH, ZERO_REG, 5'd4, 12'd1));
        send_word(enc_s(F3_SB, ZERO_REG, 5'd2, 12'd3));
        send_word(enc_i(OP_LOAD, F3_LW, EXIT_REG, ZERO_REG, 12'd0));
        send_word(enc_i(OP_LOAD, F3_LW, 5'd11, 5'd1, 12'd1));
        send_word(enc_i(OP_LOAD, F3_LBU, ZERO_REG, ZERO_REG, -12'd2));
        send_word(enc_j(5'd12, -21'd8));
        send_word(enc_j(ZERO_REG, 21'h0FFFFE));
        send_word(enc_i(OP_IMM, F3_ADD, 5'd13, ZERO_REG, 12'h101));
        // rd == rs1: target from the old value, bit 0 cleared
        send_word(enc_i(OP_JALR, F3_JALR, 5'd13, 5'd13, 12'h003));
        send_word(enc_i(OP_JALR, F3_JALR, ZERO_REG, 5'd2, 12'hFFF));
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        repeat (60) send_word(random_program_word());
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (30) send_word(random_program_word());
    endtask

    task automatic test_random();
        gaps_on = 1'b1;
        repeat (RANDOM_ITEMS) send_word(random_program_word());
    endtask

    task automatic test_halt();
        t_word w;
        gaps_on = 1'b1;
        case ($urandom_range(0, 2))
            0: w = EBREAK_WORD;
            1: w = enc_u(OP_LUI, pick_reg(), 20'($urandom()));
            default: begin
                case ($urandom_range(0, 7))
                    0: w = ECALL_WORD;
                    1: w = enc_r(F7_MUL, F3_ADD, pick_reg(), pick_reg(), pick_reg());
                    2: w = enc_r(F7_ADD, F3_SLL, pick_reg(), pick_reg(), pick_reg());
                    3: w = enc_i(OP_IMM, F3_SLL, pick_reg(), pick_reg(), 12'($urandom()));
                    4: w = enc_i(OP_LOAD, F3_LH, pick_reg(), pick_reg(), 12'($urandom()));
                    5: w = enc_s(F3_SBAD, pick_reg(), pick_reg(), 12'($urandom()));
                    6: w = enc_i(OP_BRANCH, 3'($urandom()), pick_reg(), pick_reg(),
                                 12'($urandom()));
                    default: w = $urandom() & ~32'd3;
                endcase
            end
        endcase
        send_word(w);
        // everything after the halt is answered as ignored
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(EBREAK_WORD);
        repeat (8) send_word($urandom());
    endtask

    initial begin
        arch_pc     = RESET_PC;
        arch_halted = 1'b0;
        for (int i = 0; i < REG_COUNT; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < MEM_BYTES; i++)
            arch_mem[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_backpressure();
        test_random();
        test_halt();
        s_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("rv32_subset_instruction_execute_tb passed");
        end else begin
            $display("rv32_subset_instruction_execute_tb failed");
        end
        $finish;
    end

endmodule
